>>> sv/dvnw_pkg.sv
// ============================================================================
// dvnw_pkg - shared constants and tables for the date check pipeline
// Year limits, the month-length table and the day-of-week month offsets.
// ============================================================================
package dvnw_pkg;

    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned WDAY_W  = 3;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1813;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd3;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Days in month m; zero for a month code outside January..December.
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic             leap);
        logic [DAY_W-1:0] len;
        len = '0;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Month offsets of the day-of-week formula.
    function automatic logic [WDAY_W-1:0] month_off(input logic [MONTH_W-1:0] m);
        logic [WDAY_W-1:0] off;
        off = '0;
        unique case (m)
            4'd1:    off = 3'd0;
            4'd2:    off = 3'd3;
            4'd3:    off = 3'd2;
            4'd4:    off = 3'd5;
            4'd5:    off = 3'd0;
            4'd6:    off = 3'd3;
            4'd7:    off = 3'd5;
            4'd8:    off = 3'd1;
            4'd9:    off = 3'd4;
            4'd10:   off = 3'd6;
            4'd11:   off = 3'd2;
            4'd12:   off = 3'd4;
            default: off = 3'd0;
        endcase
        return off;
    endfunction

endpackage

>>> sv/date_validate_next_weekday_core.sv
// ============================================================================
// date_validate_next_weekday_core - Gregorian date check, next date, weekday
// Checks one date per cycle, gives its leap flag, month length, day of week
// (Monday = 0) and the following date, in a four-stage pipeline.
// ============================================================================
//  channel  | handshake          | payload
//  ---------+--------------------+---------------------------------------------
//  input    | start / busy       | i_year_in, i_month_in, i_day_in
//  result   | o_valid (1 cycle)  | o_date_ok, o_leap, o_month_days, o_weekday,
//           |                    | o_next_ok, o_next_year, o_next_month,
//           |                    | o_next_day
//
//  One item per cycle; each item passes the stage registers in order.
//  Stages: divide-by-25 products, leap/length/range and weekday sum,
//  divide-by-7 product and next date, output register.
//  busy stays low: the pipeline never holds, and the receiver cannot stall.
//  Synchronous active-low reset clears the stage valid bits only.
// ============================================================================
module date_validate_next_weekday_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [13:0] i_year_in,
    input  logic [3:0]  i_month_in,
    input  logic [4:0]  i_day_in,
    output logic        o_valid,
    output logic        o_date_ok,
    output logic        o_leap,
    output logic [4:0]  o_month_days,
    output logic [2:0]  o_weekday,
    output logic        o_next_ok,
    output logic [13:0] o_next_year,
    output logic [3:0]  o_next_month,
    output logic [4:0]  o_next_day
);

    // Reciprocals: x/25 = (x*5243)>>17 for x < 16384, x/7 = (x*37450)>>18
    // for x < 16384.
    localparam logic [12:0] RECIP25 = 13'd5243;
    localparam logic [15:0] RECIP7  = 16'd37450;

    // ---------------------------------------------------------------- stage 1
    logic        r_v1;
    logic [13:0] r_y1;
    logic [3:0]  r_m1;
    logic [4:0]  r_d1;
    logic [13:0] r_yy1;
    logic [9:0]  r_qy1;   // year / 25
    logic [7:0]  r_qa1;   // (yy / 4) / 25 = yy / 100

    logic [13:0] n_yy1;
    logic [26:0] w_prod_y;
    logic [24:0] w_prod_a;

    always_comb begin
        n_yy1    = (i_month_in < dvnw_pkg::MONTH_MAR) ? 14'(i_year_in - 14'd1) : i_year_in;
        w_prod_y = 27'(i_year_in * RECIP25);
        w_prod_a = 25'(n_yy1[13:2] * RECIP25);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
        end
        r_y1  <= i_year_in;
        r_m1  <= i_month_in;
        r_d1  <= i_day_in;
        r_yy1 <= n_yy1;
        r_qy1 <= w_prod_y[26:17];
        r_qa1 <= w_prod_a[24:17];
    end

    // ---------------------------------------------------------------- stage 2
    logic        r_v2;
    logic [13:0] r_y2;
    logic [3:0]  r_m2;
    logic [4:0]  r_d2;
    logic        r_leap2;
    logic [4:0]  r_len2;
    logic        r_ok2;
    logic [14:0] r_sum2;

    logic        n_leap2;
    logic [4:0]  n_len2;
    logic        n_ok2;
    logic [14:0] n_sum2;

    always_comb begin
        // Divisible by 100 is divisible by 4 and 25; by 400 is by 16 and 25.
        n_leap2 = (r_y1[1:0] == 2'd0) &&
                  ((r_y1 != 14'(r_qy1 * 5'd25)) || (r_y1[3:0] == 4'd0));
        n_len2  = dvnw_pkg::month_len(r_m1, n_leap2);
        n_ok2   = (r_y1 >= dvnw_pkg::YEAR_MIN) && (r_y1 <= dvnw_pkg::YEAR_MAX) &&
                  (n_len2 != 5'd0) && (r_d1 != 5'd0) && (r_d1 <= n_len2);
        n_sum2  = 15'(r_yy1) + 15'(r_yy1[13:2]) - 15'(r_qa1) + 15'(r_qa1[7:2]) +
                  15'(dvnw_pkg::month_off(r_m1)) + 15'(r_d1) + 15'd6;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_y2    <= r_y1;
        r_m2    <= r_m1;
        r_d2    <= r_d1;
        r_leap2 <= n_leap2;
        r_len2  <= n_len2;
        r_ok2   <= n_ok2;
        r_sum2  <= n_sum2;
    end

    // ---------------------------------------------------------------- stage 3
    logic        r_v3;
    logic        r_leap3;
    logic [4:0]  r_len3;
    logic        r_ok3;
    logic [2:0]  r_s3;    // sum mod 8
    logic [2:0]  r_q3;    // (sum / 7) mod 8
    logic        r_nok3;
    logic [13:0] r_ny3;
    logic [3:0]  r_nm3;
    logic [4:0]  r_nd3;

    logic [30:0] w_prod_s;
    logic        w_last;
    logic        w_wrap;
    logic [13:0] n_ny3;
    logic [3:0]  n_nm3;
    logic [4:0]  n_nd3;

    always_comb begin
        w_prod_s = 31'(r_sum2 * RECIP7);
        w_last   = (r_d2 == r_len2);
        w_wrap   = w_last && (r_m2 == dvnw_pkg::MONTH_DEC);
        n_ny3    = w_wrap ? 14'(r_y2 + 14'd1) : r_y2;
        n_nm3    = w_wrap ? dvnw_pkg::MONTH_JAN : (w_last ? 4'(r_m2 + 4'd1) : r_m2);
        n_nd3    = w_last ? 5'd1 : 5'(r_d2 + 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_leap3 <= r_leap2;
        r_len3  <= r_len2;
        r_ok3   <= r_ok2;
        r_s3    <= r_sum2[2:0];
        r_q3    <= w_prod_s[20:18];
        // Zero the next date for an invalid input.
        r_nok3  <= r_ok2 && (n_ny3 <= dvnw_pkg::YEAR_MAX);
        r_ny3   <= r_ok2 ? n_ny3 : 14'd0;
        r_nm3   <= r_ok2 ? n_nm3 : 4'd0;
        r_nd3   <= r_ok2 ? n_nd3 : 5'd0;
    end

    // ---------------------------------------------------------------- stage 4
    logic        r_v4;
    logic        r_ok4;
    logic        r_leap4;
    logic [4:0]  r_len4;
    logic [2:0]  r_wd4;
    logic        r_nok4;
    logic [13:0] r_ny4;
    logic [3:0]  r_nm4;
    logic [4:0]  r_nd4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else begin
            r_v4 <= r_v3;
        end
        r_ok4   <= r_ok3;
        r_leap4 <= r_leap3;
        r_len4  <= r_len3;
        // sum - 7q is in 0..6, and -7q equals +q modulo 8.
        r_wd4   <= r_ok3 ? 3'(r_s3 + r_q3) : 3'd0;
        r_nok4  <= r_nok3;
        r_ny4   <= r_ny3;
        r_nm4   <= r_nm3;
        r_nd4   <= r_nd3;
    end

    assign busy         = 1'b0;
    assign o_valid      = r_v4;
    assign o_date_ok    = r_ok4;
    assign o_leap       = r_leap4;
    assign o_month_days = r_len4;
    assign o_weekday    = r_wd4;
    assign o_next_ok    = r_nok4;
    assign o_next_year  = r_ny4;
    assign o_next_month = r_nm4;
    assign o_next_day   = r_nd4;

endmodule

>>> sv/dvnw_checker.sv
// ============================================================================
// dvnw_checker - port-level checks for the date check pipeline
// Latency of results and consistency of the result fields.
// ============================================================================
module dvnw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_date_ok,
    input logic [4:0]  o_month_days,
    input logic [2:0]  o_weekday,
    input logic        o_next_ok,
    input logic [13:0] o_next_year,
    input logic [3:0]  o_next_month,
    input logic [4:0]  o_next_day
);

    // Every item taken while reset stays released yields a result on o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(start && !busy && i_rst_n, 4) && $past(i_rst_n, 3) &&
         $past(i_rst_n, 2) && $past(i_rst_n, 1)) |-> o_valid)
        else $error("item taken but no result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 4))
        else $error("result without a matching item");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_date_ok) |-> (o_weekday == 3'd0 && !o_next_ok &&
            o_next_year == 14'd0 && o_next_month == 4'd0 && o_next_day == 5'd0))
        else $error("invalid date with nonzero next date or weekday");

    a_valid_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_date_ok) |-> (o_weekday <= 3'd6 && o_month_days >= 5'd28 &&
            o_next_day != 5'd0 && o_next_day <= 5'd31))
        else $error("valid date with out-of-range result fields");

    a_next_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_next_ok) |-> o_date_ok)
        else $error("next date flagged valid for an invalid input");

endmodule

bind date_validate_next_weekday_core dvnw_checker u_dvnw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_date_ok    (o_date_ok),
    .o_month_days (o_month_days),
    .o_weekday    (o_weekday),
    .o_next_ok    (o_next_ok),
    .o_next_year  (o_next_year),
    .o_next_month (o_next_month),
    .o_next_day   (o_next_day)
);

>>> verif/tb_date_validate_next_weekday_core.sv
// ============================================================================
// tb_date_validate_next_weekday_core - date check / next date / weekday bench
// Sends Gregorian dates through the start/busy port and predicts each result
// from a behavioral calendar model: validity, leap flag, month length, day of
// week and the following date. Every o_valid result is compared field by field
// with the oldest prediction. Directed month ends, leap rules and field
// extremes come first, then random dates with random sender gaps, then a
// back-to-back stream.
// ============================================================================
module tb_date_validate_next_weekday_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                         date_ok;
        logic                         leap;
        logic [dvnw_pkg::DAY_W-1:0]   month_days;
        logic [dvnw_pkg::WDAY_W-1:0]  weekday;
        logic                         next_ok;
        logic [dvnw_pkg::YEAR_W-1:0]  next_year;
        logic [dvnw_pkg::MONTH_W-1:0] next_month;
        logic [dvnw_pkg::DAY_W-1:0]   next_day;
    } t_date_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [13:0] i_year_in;
    logic [3:0]  i_month_in;
    logic [4:0]  i_day_in;
    logic        o_valid;
    logic        o_date_ok;
    logic        o_leap;
    logic [4:0]  o_month_days;
    logic [2:0]  o_weekday;
    logic        o_next_ok;
    logic [13:0] o_next_year;
    logic [3:0]  o_next_month;
    logic [4:0]  o_next_day;

    t_date_result due_results[$];
    int unsigned  mismatch_count;
    bit           gaps_on;

    date_validate_next_weekday_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_year_in    (i_year_in),
        .i_month_in   (i_month_in),
        .i_day_in     (i_day_in),
        .o_valid      (o_valid),
        .o_date_ok    (o_date_ok),
        .o_leap       (o_leap),
        .o_month_days (o_month_days),
        .o_weekday    (o_weekday),
        .o_next_ok    (o_next_ok),
        .o_next_year  (o_next_year),
        .o_next_month (o_next_month),
        .o_next_day   (o_next_day)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic bit is_leap_year(input logic [dvnw_pkg::YEAR_W-1:0] y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_of_month(input logic [dvnw_pkg::YEAR_W-1:0] y,
                                                  input logic [dvnw_pkg::MONTH_W-1:0] m);
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 31;
            4'd4, 4'd6, 4'd9, 4'd11:                    return 30;
            dvnw_pkg::MONTH_FEB:                        return is_leap_year(y) ? 29 : 28;
            default:                                    return 0;
        endcase
    endfunction

    function automatic t_date_result predict_date(input logic [dvnw_pkg::YEAR_W-1:0]  y,
                                                  input logic [dvnw_pkg::MONTH_W-1:0] m,
                                                  input logic [dvnw_pkg::DAY_W-1:0]   d);
        t_date_result r;
        int unsigned  len;
        int unsigned  yy;
        int unsigned  off;
        int unsigned  sum;
        r = '0;
        r.leap = is_leap_year(y);
        len = days_of_month(y, m);
        r.month_days = 5'(len);
        r.date_ok = (y >= dvnw_pkg::YEAR_MIN) && (y <= dvnw_pkg::YEAR_MAX) &&
                    (len != 0) && (d != 0) && (d <= len);
        if (r.date_ok) begin
            // January and February count as months of the previous year
            yy = (m < dvnw_pkg::MONTH_MAR) ? 32'(y) - 32'd1 : 32'(y);
            case (m)
                4'd1, 4'd5: off = 0;
                4'd8:       off = 1;
                4'd3, 4'd11: off = 2;
                4'd2, 4'd6: off = 3;
                4'd9, 4'd12: off = 4;
                4'd4, 4'd7: off = 5;
                default:    off = 6;
            endcase
            sum = yy + yy / 4 - yy / 100 + yy / 400 + off + d + 6;
            r.weekday = 3'(sum % 7);
            r.next_year  = y;
            r.next_month = m;
            if (d == len) begin
                r.next_day = 5'd1;
                if (m == dvnw_pkg::MONTH_DEC) begin
                    r.next_month = dvnw_pkg::MONTH_JAN;
                    r.next_year  = 14'(y + 14'd1);
                end else begin
                    r.next_month = 4'(m + 4'd1);
                end
            end else begin
                r.next_day = 5'(d + 5'd1);
            end
            r.next_ok = (r.next_year <= dvnw_pkg::YEAR_MAX);
        end
        return r;
    endfunction

    // Hold the item on the port until it is taken, then queue its prediction.
    task automatic send_date(input logic [dvnw_pkg::YEAR_W-1:0]  y,
                             input logic [dvnw_pkg::MONTH_W-1:0] m,
                             input logic [dvnw_pkg::DAY_W-1:0]   d);
        @(negedge i_clk);
        start      <= 1'b1;
        i_year_in  <= y;
        i_month_in <= m;
        i_day_in   <= d;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        due_results.push_back(predict_date(y, m, d));
    endtask

    // Drop start and scramble the payload on every idle cycle.
    task automatic idle_cycles(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_year_in  <= 14'($urandom);
            i_month_in <= 4'($urandom);
            i_day_in   <= 5'($urandom);
        end
    endtask

    task automatic check_field(input string name, input logic [13:0] exp_val,
                               input logic [13:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_date_result want;
        if (i_rst_n === 1'b1 && o_valid !== 1'b0) begin
            if (due_results.size() == 0) begin
                $error("result with no item outstanding");
                mismatch_count++;
            end else begin
                want = due_results.pop_front();
                check_field("date_ok",    14'(want.date_ok),    14'(o_date_ok));
                check_field("leap",       14'(want.leap),       14'(o_leap));
                check_field("month_days", 14'(want.month_days), 14'(o_month_days));
                check_field("weekday",    14'(want.weekday),    14'(o_weekday));
                check_field("next_ok",    14'(want.next_ok),    14'(o_next_ok));
                check_field("next_year",  want.next_year,       o_next_year);
                check_field("next_month", 14'(want.next_month), 14'(o_next_month));
                check_field("next_day",   14'(want.next_day),   14'(o_next_day));
            end
        end
    end

    task automatic test_field_extremes();
        send_date(14'd0, 4'd0, 5'd0);
        send_date(14'd16383, 4'd15, 5'd31);
        send_date(14'd1812, dvnw_pkg::MONTH_DEC, 5'd31);
        send_date(dvnw_pkg::YEAR_MIN, dvnw_pkg::MONTH_JAN, 5'd1);
        // last day of the range rolls into a year the block calls invalid
        send_date(dvnw_pkg::YEAR_MAX, dvnw_pkg::MONTH_DEC, 5'd31);
        send_date(14'd10000, dvnw_pkg::MONTH_JAN, 5'd1);
        send_date(14'd2024, 4'd13, 5'd1);
        send_date(14'd2023, 4'd4, 5'd31);
    endtask

    task automatic test_leap_rules();
        send_date(14'd2000, dvnw_pkg::MONTH_FEB, 5'd29);
        send_date(14'd1900, dvnw_pkg::MONTH_FEB, 5'd29);
        send_date(14'd2024, dvnw_pkg::MONTH_FEB, 5'd29);
        send_date(14'd2023, dvnw_pkg::MONTH_FEB, 5'd29);
        send_date(14'd2100, dvnw_pkg::MONTH_FEB, 5'd28);
        // leap flag still reported with no valid month
        send_date(14'd2000, 4'd0, 5'd0);
    endtask

    task automatic test_month_ends();
        logic [dvnw_pkg::MONTH_W-1:0] m;
        for (int i = 1; i <= 12; i++) begin
            m = 4'(i);
            send_date(14'd2023, m, 5'(days_of_month(14'd2023, m)));
        end
    endtask

    // Mostly valid dates, biased to month ends and range edges, plus noise.
    task automatic send_random_date();
        logic [dvnw_pkg::YEAR_W-1:0]  y;
        logic [dvnw_pkg::MONTH_W-1:0] m;
        int unsigned                  len;
        int unsigned                  pick;
        int unsigned                  d;
        if ($urandom_range(0, 4) == 0) begin
            send_date(14'($urandom), 4'($urandom), 5'($urandom));
        end else begin
            pick = $urandom_range(0, 15);
            case (pick)
                0:       y = 14'(dvnw_pkg::YEAR_MIN - 14'd1);
                1:       y = dvnw_pkg::YEAR_MIN;
                2, 3:    y = dvnw_pkg::YEAR_MAX;
                4:       y = 14'(dvnw_pkg::YEAR_MAX + 14'd1);
                5:       y = 14'(400 * $urandom_range(5, 24));
                6:       y = 14'(100 * $urandom_range(19, 99));
                default: y = 14'($urandom_range(dvnw_pkg::YEAR_MIN, dvnw_pkg::YEAR_MAX));
            endcase
            m = 4'($urandom_range(1, 12));
            len = days_of_month(y, m);
            case ($urandom_range(0, 7))
                0, 1:    d = len;
                2:       d = len + 1;
                3:       d = 1;
                4:       d = len - 1;
                default: d = $urandom_range(1, len);
            endcase
            send_date(y, m, 5'(d));
        end
    endtask

    task automatic test_random_dates(input int unsigned n);
        gaps_on = 1'b1;
        repeat (n) begin
            if ($urandom_range(0, 39) == 0) gaps_on = ~gaps_on;
            if (gaps_on && $urandom_range(0, 3) == 0)
                idle_cycles($urandom_range(1, 17));
            send_random_date();
        end
    endtask

    task automatic test_back_to_back(input int unsigned n);
        repeat (n) send_random_date();
    endtask

    initial begin
        int unsigned guard;
        mismatch_count = 0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_year_in  <= '0;
        i_month_in <= '0;
        i_day_in   <= '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_field_extremes();
        test_leap_rules();
        test_month_ends();
        test_random_dates(970);
        test_back_to_back(150);

        @(negedge i_clk);
        start <= 1'b0;
        guard = 0;
        while (due_results.size() != 0 && guard < 1000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (8) @(posedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d results never arrived", due_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
sv/dvnw_pkg.sv
sv/date_validate_next_weekday_core.sv
sv/dvnw_checker.sv
verif/tb_date_validate_next_weekday_core.sv
